@@ rtl/thmc_pkg.sv @@
// Package for the thermostat heater mode control unit.
// Holds the mode codes, register map, reset values and field widths.
// No dependencies.
package thmc_pkg;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_AUTO = 3'd1,
    MODE_OFF  = 3'd2,
    MODE_ON   = 3'd3,
    MODE_SAFE = 3'd4
  } mode_t;

  // Register word indexes, at byte address 4 * index.
  typedef enum logic [2:0] {
    REG_SET_TEMPERATURE = 3'd0,
    REG_MAX_TEMPERATURE = 3'd1,
    REG_NIGHT_ON_MS     = 3'd2,
    REG_NIGHT_OFF_MS    = 3'd3,
    REG_DAY_ON_MS       = 3'd4,
    REG_DAY_OFF_MS      = 3'd5
  } reg_idx_t;

  localparam int TEMP_W    = 8;
  localparam int MS_W      = 23;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int ELAPSED_W = 16;
  localparam int DAYMIN_W  = 11;
  localparam int ADDR_W    = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic signed [TEMP_W-1:0] SET_TEMP_RESET = 8'sd26;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 8'sd30;
  localparam logic [MS_W-1:0] NIGHT_ON_RESET  = 23'd3600000;
  localparam logic [MS_W-1:0] NIGHT_OFF_RESET = 23'd1800000;
  localparam logic [MS_W-1:0] DAY_ON_RESET    = 23'd1800000;
  localparam logic [MS_W-1:0] DAY_OFF_RESET   = 23'd7200000;
  localparam logic [MS_W-1:0] TIMER_MAX       = 23'd8388607;

  // Night is after 20:30 or before 8:30, in minutes of the day.
  localparam logic [DAYMIN_W-1:0] NIGHT_START_MIN = 11'd1230;
  localparam logic [DAYMIN_W-1:0] NIGHT_END_MIN   = 11'd510;
  localparam logic [DAYMIN_W-1:0] MIN_PER_HOUR    = 11'd60;

endpackage

@@ rtl/thermostat_heater_mode_control_unit.sv @@
// Top level of the thermostat heater mode control unit.
// Depends on thmc_pkg for mode codes, register map and reset values.
//
// Usage: one input beat on the s_ channel is one evaluation of the
// thermostat; each one yields exactly one result beat on the m_ channel.
// The six setting registers sit on the APB port at byte address 4 * index;
// the user must write them only while the unit is idle, which the unit
// does not enforce; reads return their values. An accepted beat is
// registered, then evaluated against the heater, mode and phase timer state
// with its result registered onto m_tvalid. Throughput is one beat per cycle
// unless m_tready stalls, set by the single evaluation stage that updates state.
// When the receiver stalls, the result beat holds in the output register
// and one further beat waits in the input register; s_tready then drops.
// Reset (rst, synchronous, active high) restores the register defaults,
// turns the heater off, clears the mode to none, clears the phase timer and
// empties both stages. Safe mode, once entered on a sensor failure, stays
// until reset.
module thermostat_heater_mode_control_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // temperature[7:0], auto_switch_n[8], off_switch_n[9], on_switch_n[10],
  // sensor_failed[11], hour[16:12], minute[22:17], elapsed_ms[38:23], zero[39]
  input  logic [thmc_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // heater_drive[0], active_mode[3:1], heater_toggled[4], is_night[5],
  // zero[7:6]
  output logic [thmc_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [thmc_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // Setting registers
  logic signed [thmc_pkg::TEMP_W-1:0] set_temperature;
  logic signed [thmc_pkg::TEMP_W-1:0] max_temperature;
  logic [thmc_pkg::MS_W-1:0]          night_on_ms;
  logic [thmc_pkg::MS_W-1:0]          night_off_ms;
  logic [thmc_pkg::MS_W-1:0]          day_on_ms;
  logic [thmc_pkg::MS_W-1:0]          day_off_ms;

  logic                cfg_write;
  thmc_pkg::reg_idx_t  cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = thmc_pkg::reg_idx_t'(paddr[thmc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_temperature <= thmc_pkg::SET_TEMP_RESET;
      max_temperature <= thmc_pkg::MAX_TEMP_RESET;
      night_on_ms     <= thmc_pkg::NIGHT_ON_RESET;
      night_off_ms    <= thmc_pkg::NIGHT_OFF_RESET;
      day_on_ms       <= thmc_pkg::DAY_ON_RESET;
      day_off_ms      <= thmc_pkg::DAY_OFF_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        thmc_pkg::REG_SET_TEMPERATURE: set_temperature <= pwdata[thmc_pkg::TEMP_W-1:0];
        thmc_pkg::REG_MAX_TEMPERATURE: max_temperature <= pwdata[thmc_pkg::TEMP_W-1:0];
        thmc_pkg::REG_NIGHT_ON_MS:     night_on_ms     <= pwdata[thmc_pkg::MS_W-1:0];
        thmc_pkg::REG_NIGHT_OFF_MS:    night_off_ms    <= pwdata[thmc_pkg::MS_W-1:0];
        thmc_pkg::REG_DAY_ON_MS:       day_on_ms       <= pwdata[thmc_pkg::MS_W-1:0];
        thmc_pkg::REG_DAY_OFF_MS:      day_off_ms      <= pwdata[thmc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      thmc_pkg::REG_SET_TEMPERATURE: prdata = 32'(set_temperature);
      thmc_pkg::REG_MAX_TEMPERATURE: prdata = 32'(max_temperature);
      thmc_pkg::REG_NIGHT_ON_MS:     prdata = 32'(night_on_ms);
      thmc_pkg::REG_NIGHT_OFF_MS:    prdata = 32'(night_off_ms);
      thmc_pkg::REG_DAY_ON_MS:       prdata = 32'(day_on_ms);
      thmc_pkg::REG_DAY_OFF_MS:      prdata = 32'(day_off_ms);
      default:                       prdata = 32'd0;
    endcase
  end

  // Pipeline control: the output register frees up when it is empty or taken.
  logic in_valid;
  logic advance;
  logic in_load;

  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = ~in_valid | advance;
  assign in_load  = s_tvalid & s_tready;

  // Input register
  logic signed [thmc_pkg::TEMP_W-1:0] temperature;
  logic                               auto_switch_n;
  logic                               off_switch_n;
  logic                               on_switch_n;
  logic                               sensor_failed;
  logic [thmc_pkg::HOUR_W-1:0]        hour;
  logic [thmc_pkg::MINUTE_W-1:0]      minute;
  logic [thmc_pkg::ELAPSED_W-1:0]     elapsed_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      temperature   <= s_tdata[7:0];
      auto_switch_n <= s_tdata[8];
      off_switch_n  <= s_tdata[9];
      on_switch_n   <= s_tdata[10];
      sensor_failed <= s_tdata[11];
      hour          <= s_tdata[16:12];
      minute        <= s_tdata[22:17];
      elapsed_ms    <= s_tdata[38:23];
    end
  end

  // Evaluation stage state
  logic                      heater_state;
  thmc_pkg::mode_t           mode_state;
  logic [thmc_pkg::MS_W-1:0] phase_timer;

  logic                      heater_state_next;
  thmc_pkg::mode_t           mode_state_next;
  logic [thmc_pkg::MS_W-1:0] phase_timer_next;

  logic [thmc_pkg::DAYMIN_W-1:0] day_min;
  logic                          night;
  logic [thmc_pkg::MS_W-1:0]     period;
  logic [thmc_pkg::MS_W:0]       timer_sum;
  logic                          step;

  assign step    = in_valid & advance;
  assign day_min = thmc_pkg::DAYMIN_W'(hour) * thmc_pkg::MIN_PER_HOUR
                 + thmc_pkg::DAYMIN_W'(minute);
  assign night   = (day_min > thmc_pkg::NIGHT_START_MIN) ||
                   (day_min < thmc_pkg::NIGHT_END_MIN);

  always_comb begin
    if (sensor_failed || mode_state == thmc_pkg::MODE_SAFE) begin
      mode_state_next = thmc_pkg::MODE_SAFE;
    end else if (!auto_switch_n) begin
      mode_state_next = thmc_pkg::MODE_AUTO;
    end else if (!off_switch_n) begin
      mode_state_next = thmc_pkg::MODE_OFF;
    end else if (!on_switch_n) begin
      mode_state_next = thmc_pkg::MODE_ON;
    end else begin
      mode_state_next = mode_state;
    end
  end

  always_comb begin
    if (heater_state) begin
      period = night ? night_on_ms : day_on_ms;
    end else begin
      period = night ? night_off_ms : day_off_ms;
    end
    timer_sum = {1'b0, phase_timer} + (thmc_pkg::MS_W + 1)'(elapsed_ms);
  end

  always_comb begin
    heater_state_next = heater_state;
    phase_timer_next  = phase_timer;
    case (mode_state_next)
      thmc_pkg::MODE_AUTO: heater_state_next = (set_temperature > temperature);
      thmc_pkg::MODE_ON:   heater_state_next = (max_temperature > temperature);
      thmc_pkg::MODE_OFF:  heater_state_next = 1'b0;
      thmc_pkg::MODE_SAFE: begin
        if (phase_timer > period) begin
          phase_timer_next  = '0;
          heater_state_next = ~heater_state;
        end else if (timer_sum[thmc_pkg::MS_W]) begin
          phase_timer_next = thmc_pkg::TIMER_MAX;
        end else begin
          phase_timer_next = timer_sum[thmc_pkg::MS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_state <= 1'b0;
      mode_state   <= thmc_pkg::MODE_NONE;
      phase_timer  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (step) begin
        heater_state <= heater_state_next;
        mode_state   <= mode_state_next;
        phase_timer  <= phase_timer_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, night, heater_state_next ^ heater_state,
                  mode_state_next, heater_state_next};
    end
  end

endmodule
